// ----- rtl/core/ssdp_pkg.sv -----
// Shared constants, types and helpers of the snoop destination predictor.
package ssdp_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int NODES         = 16;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int MASK_W = 16;
  localparam int ADDR_W = 48;
  localparam int NODE_W = 4;
  localparam int ACT_W  = 2;
  localparam int WIN_W  = 9;
  // holds twice the window as well as the table size
  localparam int SPAN_W = (WIN_W + 1 > CNT_W) ? WIN_W + 1 : CNT_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_MASK     = 1'b1;

  // request actions
  localparam logic [ACT_W-1:0] ACT_PREDICT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INVAL   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_NBR,
    ST_WB,
    ST_RESULT
  } state_t;

  // one table word: present flag, valid (present and nonzero tag), mask
  typedef struct packed {
    logic              present;
    logic              valid;
    logic [MASK_W-1:0] mask;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [MASK_W-1:0] node_bit(input logic [NODE_W-1:0] node);
    logic [MASK_W-1:0] res;
    res = '0;
    if (int'(node) < NODES && int'(node) < MASK_W) begin
      res = MASK_W'(1) << node;
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/ssdp_if.sv -----
// Request and result channel interfaces of the snoop destination predictor.
interface ssdp_in_if
  import ssdp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ADDR_W-1:0] address;
  logic [NODE_W-1:0] requester;
  logic [NODE_W-1:0] provider;
  logic [MASK_W-1:0] initial_mask;

  modport source (output valid, action, address, requester, provider, initial_mask,
                  input ready);
  modport sink   (input valid, action, address, requester, provider, initial_mask,
                  output ready);
endinterface

interface ssdp_out_if
  import ssdp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] dest_mask;
  logic              entry_valid;

  modport source (output valid, dest_mask, entry_valid, input ready);
  modport sink   (input valid, dest_mask, entry_valid, output ready);
endinterface

// ----- rtl/core/ssdp_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
module ssdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/sticky_snoop_destination_predictor.sv -----
// Top level of the sticky snoop destination predictor.
// A direct-mapped table of TABLE_ENTRIES words, indexed by the low address bits, holds per
// entry a present flag, a valid flag (present with a nonzero tag) and a node mask, all in
// one single-port-read RAM. Each request gives one result. After reset a clearing pass
// writes every table word, one per cycle, before the first request is taken;
// configuration writes are taken throughout. An add, an invalidate or a predict that does
// not look at neighbours passes through accept, table read and result.
// A predict on a valid entry with enough present entries reads 2*w neighbours, one per
// cycle through the RAM read port, w being window_half clamped to TABLE_ENTRIES/2-1 when
// twice it exceeds the table, and then writes back the widened mask. The result register
// decouples the output: the next request is accepted while a result waits to be taken.
module sticky_snoop_destination_predictor
  import ssdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ssdp_in_if.sink               in_req,
  ssdp_out_if.source            out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  // configuration
  logic [WIN_W-1:0]  window_half_r;
  logic [MASK_W-1:0] l2_mask_r;

  logic [CNT_W-1:0]  present_count_r, present_count_nxt;
  logic [IDX_W-1:0]  clr_addr_r, clr_addr_nxt;

  // request held while it is worked on
  logic [ACT_W-1:0]  act_r;
  logic [IDX_W-1:0]  idx_r;
  logic              addr_nz_r;
  logic [NODE_W-1:0] req_r;
  logic [NODE_W-1:0] prov_r;
  logic [MASK_W-1:0] init_mask_r;

  // neighbour sweep
  logic [MASK_W-1:0] acc_r, acc_nxt;
  logic [MASK_W-1:0] base_r, base_nxt;
  logic              ev_r, ev_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic [SPAN_W-1:0] cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [MASK_W-1:0] res_dest_r, res_dest_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_dest_r;
  logic              out_ev_r;
  logic              out_load;

  // table port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            ent;

  logic              accept;
  logic [SPAN_W-1:0] two_w, span_eff;
  logic              enough;
  logic [IDX_W-1:0]  nbr_off, nbr_up, nbr_dn;
  logic              issue;

  assign accept = in_req.valid && in_req.ready;
  assign ent    = entry_t'(ram_rdata);

  // effective neighbour count, clamped for wide windows
  assign two_w    = SPAN_W'({window_half_r, 1'b0});
  assign span_eff = (two_w > SPAN_W'(TABLE_ENTRIES)) ? SPAN_W'(TABLE_ENTRIES - 2) : two_w;
  assign enough   = span_eff <= SPAN_W'(present_count_r);

  // even steps go up, odd steps go down; distance is step/2 + 1, wrapping
  assign nbr_off = IDX_W'((cnt_r >> 1) + SPAN_W'(1));
  assign nbr_up  = idx_r + nbr_off;
  assign nbr_dn  = idx_r - nbr_off;
  assign issue   = cnt_r != span_r;

  ssdp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      window_half_r   <= WIN_RESET;
      l2_mask_r       <= '0;
      present_count_r <= '0;
      clr_addr_r      <= '0;
      out_valid_r     <= 1'b0;
      pend_r          <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      present_count_r <= present_count_nxt;
      clr_addr_r      <= clr_addr_nxt;
      out_valid_r     <= out_valid_nxt;
      pend_r          <= pend_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_WINDOW_HALF: window_half_r <= cfg_data[WIN_W-1:0];
          CFG_L2_MASK:     l2_mask_r     <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r       <= in_req.action;
      idx_r       <= in_req.address[IDX_W-1:0];
      addr_nz_r   <= in_req.address != '0;
      req_r       <= in_req.requester;
      prov_r      <= in_req.provider;
      init_mask_r <= in_req.initial_mask;
    end
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    ev_r       <= ev_nxt;
    span_r     <= span_nxt;
    cnt_r      <= cnt_nxt;
    res_dest_r <= res_dest_nxt;
    if (out_load) begin
      out_dest_r <= res_dest_r;
      out_ev_r   <= ev_r;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    present_count_nxt = present_count_r;
    clr_addr_nxt      = clr_addr_r;
    acc_nxt           = acc_r;
    base_nxt          = base_r;
    ev_nxt            = ev_r;
    span_nxt          = span_r;
    cnt_nxt           = cnt_r;
    pend_nxt          = 1'b0;
    res_dest_nxt      = res_dest_r;
    ram_we            = 1'b0;
    ram_waddr         = idx_r;
    ram_wdata         = '0;
    ram_raddr         = idx_r;
    out_load          = 1'b0;
    in_req.ready      = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_req.ready = 1'b1;
        ram_raddr    = in_req.address[IDX_W-1:0];
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end

      // indexed entry is on the read port now
      ST_LOOK: begin
        ev_nxt       = ent.valid;
        res_dest_nxt = '0;
        state_nxt    = ST_RESULT;
        unique case (act_r)
          ACT_PREDICT: begin
            base_nxt     = node_bit(req_r) | l2_mask_r;
            acc_nxt      = ent.mask;
            res_dest_nxt = node_bit(req_r) | l2_mask_r | (ent.valid ? ent.mask : '0);
            // zero window would write the mask back unchanged: skip it
            if (ent.valid && enough && span_eff != '0) begin
              span_nxt  = span_eff;
              cnt_nxt   = '0;
              state_nxt = ST_NBR;
            end
          end
          ACT_ADD: begin
            ram_we = 1'b1;
            if (ent.valid) begin
              ram_wdata = '{present: 1'b1, valid: 1'b1, mask: ent.mask | node_bit(prov_r)};
            end else begin
              ram_wdata = '{present: 1'b1, valid: addr_nz_r, mask: init_mask_r};
              if (!ent.present) begin
                present_count_nxt = present_count_r + CNT_W'(1);
              end
            end
          end
          ACT_INVAL: begin
            if (ent.valid) begin
              ram_we    = 1'b1;
              ram_wdata = '{present: 1'b1, valid: 1'b0, mask: '0};
            end
          end
          default: ;
        endcase
      end

      // one neighbour read issued per cycle, its data consumed in the cycle after
      ST_NBR: begin
        ram_raddr = cnt_r[0] ? nbr_dn : nbr_up;
        if (issue) begin
          cnt_nxt  = cnt_r + SPAN_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && ent.valid) begin
          acc_nxt = acc_r | ent.mask;
        end
        if (!issue && !pend_r) begin
          state_nxt = ST_WB;
        end
      end

      ST_WB: begin
        ram_we       = 1'b1;
        ram_wdata    = '{present: 1'b1, valid: 1'b1, mask: acc_r};
        res_dest_nxt = base_r | acc_r;
        state_nxt    = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.dest_mask   = out_dest_r;
  assign out_rsp.entry_valid = out_ev_r;

endmodule

// ----- rtl/core/ssdp_checker.sv -----
// Port-level assertions for the snoop destination predictor, bound to the top level.
module ssdp_checker
  import ssdp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MASK_W-1:0] out_dest_mask,
  input logic              out_entry_valid
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_dest_mask) && $stable(out_entry_valid))
    else $error("result payload changed while stalled");

  // one request at a time: never ready right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // clearing pass holds off requests after reset
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("request taken before table clear");

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sticky_snoop_destination_predictor ssdp_checker u_ssdp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_dest_mask  (out_rsp.dest_mask),
  .out_entry_valid(out_rsp.entry_valid)
);
